@@ rtl/core/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the NTC temperature converter
// Item classes, status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ntc_pkg;

  typedef enum logic [1:0] {
    KIND_CALC  = 2'd0,
    KIND_VREF0 = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_ZERO  = 2'd3
  } ntc_kind_e;

  typedef struct packed {
    ntc_kind_e   kind;
    logic [15:0] s;   // divider sample
    logic [15:0] n;   // full scale minus sample
  } ntc_item_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_VREF0 = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_SAT   = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  localparam logic [1:0]  REG_BETA    = 2'd0;
  localparam logic [1:0]  REG_NOMINAL = 2'd1;
  localparam logic [1:0]  REG_FULL    = 2'd2;

  localparam logic [15:0] ZERO_C_CENTI = 16'd27315;
  localparam logic [15:0] NEG_ZERO_C   = 16'h954D;  // -27315
  localparam logic [15:0] TEMP_MAX     = 16'h7FFF;
  localparam logic [15:0] TEMP_MIN     = 16'h8000;
  localparam logic [63:0] LN2_Q64      = 64'hB17217F7D1CF79AC;
  localparam logic [41:0] QUOT_CAP     = 42'h100_0000_0000;
  localparam logic [5:0]  FRAC_TOP     = 6'd47;
  localparam logic [6:0]  DIV_TOP      = 7'd70;
  localparam logic [6:0]  NUM_SHIFT    = 7'd33;

endpackage

@@ rtl/core/ntc_if.sv @@
// ----------------------------------------------------------------------------
// ntc_in_if / ntc_out_if: valid-ready channels of the converter
// Sample words in, temperature words out.
// ----------------------------------------------------------------------------
interface ntc_in_if #(parameter int ADC_BITS = 12);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic [ADC_BITS-1:0] vref_sample;
  modport source(output valid, output adc_sample, output vref_sample, input ready);
  modport sink(input valid, input adc_sample, input vref_sample, output ready);
endinterface

interface ntc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi;
  logic [2:0]         status;
  modport source(output valid, output temp_centi, output status, input ready);
  modport sink(input valid, input temp_centi, input status, output ready);
endinterface

@@ rtl/core/ntc_adc_to_celsius_core.sv @@
// ----------------------------------------------------------------------------
// ntc_adc_to_celsius_core: NTC thermistor sample to hundredths of a degree C
// Beta-equation conversion with a classifying front, a queue and an
// iterative arithmetic back end.
// ----------------------------------------------------------------------------
// Sequence: special cases (zero reference, sample at/above full scale, zero
//   sample) are answered straight from the idle state; a full conversion
//   runs two 48-step log2 runs by squaring on the shared 32x32 multiplier,
//   each after a setup state, three products, a 71-step division and the
//   output state. Throughput: one special word per cycle while the back
//   end is idle and the sink is ready; conversions run one at a time.
// Reset: asynchronous, active low; registers return to beta 3950,
//   nominal 25 C, full scale 4095, and queue and output are emptied.
module ntc_adc_to_celsius_core #(
  parameter int ADC_BITS = 12,
  parameter int Q_DEPTH  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntc_in_if.sink      in_i,
  ntc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import ntc_pkg::*;

  // Configuration registers. Writes must arrive only while the core is idle; the core does not enforce this.
  logic [15:0] beta_q;
  logic [6:0]  nominal_q;
  logic [15:0] full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q    <= 16'd3950;
      nominal_q <= 7'd25;
      full_q    <= 16'd4095;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BETA:    beta_q    <= cfg_data_i;
        REG_NOMINAL: nominal_q <= cfg_data_i[6:0];
        REG_FULL:    full_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // The front classifies each accepted word and pushes it into the queue.
  logic      q_full, q_push, q_valid, q_pop;
  ntc_item_t q_in, q_out;

  ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .valid_i       (in_i.valid),
    .adc_sample_i  (in_i.adc_sample),
    .vref_sample_i (in_i.vref_sample),
    .full_scale_i  (full_q),
    .q_full_i      (q_full),
    .ready_o       (in_i.ready),
    .push_o        (q_push),
    .item_o        (q_in)
  );

  ntc_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // The back end owns the output register; a finished word waiting on the
  // sink stalls it, and the front accepts new samples until the queue fills.
  logic [15:0] res_temp;

  ntc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beta_i       (beta_q),
    .nominal_i    (nominal_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_temp_o   (res_temp),
    .res_status_o (out_o.status)
  );

  assign out_o.temp_centi = $signed(res_temp);

  // The back end only pops a queue that holds an item.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // A zero reference is always classified as such.
  a_vref_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && in_i.vref_sample == '0) |-> (q_in.kind == KIND_VREF0))
    else $error("zero reference misclassified");

  // An unsaturated conversion never falls below absolute zero.
  a_abs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_OK) |-> (out_o.temp_centi >= -16'sd27315))
    else $error("result below absolute zero");

  // No push when the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push) else $error("queue overflow");

endmodule

@@ rtl/core/ntc_front.sv @@
// ----------------------------------------------------------------------------
// ntc_front: sample classification
// Sorts each sample word into a special case or a full conversion.
// ----------------------------------------------------------------------------
module ntc_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                valid_i,
  input  logic [ADC_BITS-1:0] adc_sample_i,
  input  logic [ADC_BITS-1:0] vref_sample_i,
  input  logic [15:0]         full_scale_i,
  input  logic                q_full_i,
  output logic                ready_o,
  output logic                push_o,
  output ntc_pkg::ntc_item_t  item_o
);
  import ntc_pkg::*;

  logic [15:0] s_ext;

  assign s_ext   = 16'(adc_sample_i);
  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;

  always_comb begin
    item_o.s = s_ext;
    item_o.n = full_scale_i - s_ext;
    if (vref_sample_i == '0) begin
      item_o.kind = KIND_VREF0;
    end else if (s_ext >= full_scale_i) begin
      item_o.kind = KIND_FULL;
    end else if (s_ext == 16'd0) begin
      item_o.kind = KIND_ZERO;
    end else begin
      item_o.kind = KIND_CALC;
    end
  end
endmodule

@@ rtl/core/ntc_queue.sv @@
// ----------------------------------------------------------------------------
// ntc_queue: small FIFO between classification and arithmetic
// Holds classified items so either side can stall on its own.
// ----------------------------------------------------------------------------
module ntc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ntc_pkg::ntc_item_t item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output ntc_pkg::ntc_item_t item_o
);
  import ntc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ntc_item_t     mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ rtl/core/ntc_back.sv @@
// ----------------------------------------------------------------------------
// ntc_back: beta-equation arithmetic sequencer
// Two log2 runs by squaring, ln2 scaling, denominator, restoring division.
// ----------------------------------------------------------------------------
module ntc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        beta_i,
  input  logic [6:0]         nominal_i,
  input  logic               q_valid_i,
  input  ntc_pkg::ntc_item_t q_item_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [15:0]        res_temp_o,
  output logic [2:0]         res_status_o
);
  import ntc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_LN2   = 3'd3;
  localparam logic [2:0] S_XT    = 3'd4;
  localparam logic [2:0] S_NUM   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]   st_q;
  logic [2:0]   ph_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [63:0]  opa_q, opb_q;
  logic         sel_q;
  logic [5:0]   it_q;
  logic [3:0]   k_q;
  logic [47:0]  frac_q;
  logic [51:0]  lp_q;
  logic [15:0]  sp_q, np_q;
  logic         neg_q;
  logic [63:0]  den_q;
  logic [37:0]  num_q;
  logic [63:0]  r_q;
  logic [41:0]  q_q;
  logic [6:0]   i_q;
  logic [15:0]  rt_q;
  logic [2:0]   rs_q;
  logic         res_valid_q;
  logic [15:0]  res_temp_q;
  logic [2:0]   res_status_q;

  // Shared 32x32 multiplier; four partial products accumulate into acc_q.
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [127:0] accsum;
  logic         mul_last;

  assign mul_a    = ph_q[1] ? opa_q[63:32] : opa_q[31:0];
  assign mul_b    = ph_q[0] ? opb_q[63:32] : opb_q[31:0];
  assign mul_p    = mul_a * mul_b;
  assign accsum   = acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
  assign mul_last = (ph_q == 3'd4);

  // Log setup: normalize n so its top bit lands on bit 62.
  logic [15:0] n_c;
  logic [3:0]  k_c;
  logic [63:0] mlog_c;

  assign n_c = sel_q ? np_q : sp_q;
  always_comb begin
    k_c = '0;
    for (int b = 0; b < 16; b++) begin
      if (n_c[b]) begin
        k_c = 4'(b);
      end
    end
  end
  assign mlog_c = {48'd0, n_c} << (6'd62 - {2'd0, k_c});

  // Squaring step.
  logic [63:0] sqm_c, mnew_c;
  logic [47:0] fnext_c;
  logic [51:0] lv_c, mag_c;
  logic        neg_c;

  assign sqm_c   = accsum[125:62];
  assign mnew_c  = sqm_c[63] ? (sqm_c >> 1) : sqm_c;
  assign fnext_c = frac_q | ({47'd0, sqm_c[63]} << it_q);
  assign lv_c    = {k_q, fnext_c};
  assign neg_c   = lp_q < lv_c;
  assign mag_c   = neg_c ? (lv_c - lp_q) : (lp_q - lv_c);

  // Constants of the nominal point.
  logic [15:0] t0c_c;
  logic [22:0] b100_c;
  assign t0c_c  = 16'(nominal_i) * 16'd100 + ZERO_C_CENTI;
  assign b100_c = 23'(beta_i) * 23'd100;

  logic [63:0]        xm_c, b100sh_c;
  logic signed [63:0] dens_c;
  assign xm_c     = (accsum[127:64] + 64'h8000) >> 16;
  assign b100sh_c = {9'd0, b100_c, 32'd0};
  assign dens_c   = neg_q ? $signed(b100sh_c - accsum[63:0])
                          : $signed(b100sh_c + accsum[63:0]);

  // Division step.
  logic [6:0]   nidx_c;
  logic         nb_c, ge_c;
  logic [63:0]  rn_c, rr_c;
  logic [41:0]  qn_c, qc_c;
  logic [41:0]  kel_c;
  logic signed [43:0] tmp_c;

  assign nidx_c = i_q - NUM_SHIFT;
  assign nb_c   = (i_q >= NUM_SHIFT) ? num_q[nidx_c[5:0]] : 1'b0;
  assign rn_c   = {r_q[62:0], nb_c};
  assign ge_c   = rn_c >= den_q;
  assign rr_c   = ge_c ? (rn_c - den_q) : rn_c;
  assign qn_c   = {q_q[40:0], ge_c};
  assign qc_c   = (qn_c > QUOT_CAP) ? QUOT_CAP : qn_c;
  assign kel_c  = (qc_c + 42'd1) >> 1;
  assign tmp_c  = $signed({2'b00, kel_c}) - $signed({28'd0, ZERO_C_CENTI});

  logic out_free, take;
  assign out_free = !res_valid_q || res_ready_i;
  assign take     = (st_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      res_valid_q  <= 1'b0;
      ph_q         <= '0;
      pp_q         <= '0;
      sh_q         <= '0;
      acc_q        <= '0;
      opa_q        <= '0;
      opb_q        <= '0;
      sel_q        <= 1'b0;
      it_q         <= '0;
      k_q          <= '0;
      frac_q       <= '0;
      lp_q         <= '0;
      sp_q         <= '0;
      np_q         <= '0;
      neg_q        <= 1'b0;
      den_q        <= '0;
      num_q        <= '0;
      r_q          <= '0;
      q_q          <= '0;
      i_q          <= '0;
      rt_q         <= '0;
      rs_q         <= '0;
      res_temp_q   <= '0;
      res_status_q <= '0;
    end else begin
      if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (st_q == S_SQ || st_q == S_LN2 || st_q == S_XT || st_q == S_NUM) begin
        if (!ph_q[2]) begin
          pp_q <= mul_p;
          sh_q <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
          ph_q <= ph_q + 3'd1;
        end
        if (ph_q != 3'd0) begin
          acc_q <= accsum;
        end
        if (mul_last) begin
          ph_q  <= '0;
          acc_q <= '0;
        end
      end
      case (st_q)
        S_IDLE: begin
          if (take) begin
            case (q_item_i.kind)
              KIND_CALC: begin
                sp_q  <= q_item_i.s;
                np_q  <= q_item_i.n;
                sel_q <= 1'b0;
                st_q  <= S_SETUP;
              end
              KIND_VREF0: begin
                res_valid_q  <= 1'b1;
                res_temp_q   <= '0;
                res_status_q <= ST_VREF0;
              end
              KIND_FULL: begin
                res_valid_q  <= 1'b1;
                res_temp_q   <= NEG_ZERO_C;
                res_status_q <= ST_FULL;
              end
              default: begin
                res_valid_q  <= 1'b1;
                res_temp_q   <= NEG_ZERO_C;
                res_status_q <= ST_ZERO;
              end
            endcase
          end
        end
        S_SETUP: begin
          opa_q  <= mlog_c;
          opb_q  <= mlog_c;
          frac_q <= '0;
          it_q   <= FRAC_TOP;
          k_q    <= k_c;
          ph_q   <= '0;
          acc_q  <= '0;
          st_q   <= S_SQ;
        end
        S_SQ: begin
          if (mul_last) begin
            opa_q  <= mnew_c;
            opb_q  <= mnew_c;
            frac_q <= fnext_c;
            it_q   <= it_q - 6'd1;
            if (it_q == 6'd0) begin
              if (!sel_q) begin
                lp_q  <= lv_c;
                sel_q <= 1'b1;
                st_q  <= S_SETUP;
              end else begin
                neg_q <= neg_c;
                opa_q <= {12'd0, mag_c};
                opb_q <= LN2_Q64;
                st_q  <= S_LN2;
              end
            end
          end
        end
        S_LN2: begin
          if (mul_last) begin
            opa_q <= xm_c;
            opb_q <= {48'd0, t0c_c};
            st_q  <= S_XT;
          end
        end
        S_XT: begin
          if (mul_last) begin
            if (dens_c[63] || dens_c == 64'sd0) begin
              rt_q <= TEMP_MAX;
              rs_q <= ST_SAT;
              st_q <= S_OUT;
            end else begin
              den_q <= dens_c;
              opa_q <= {41'd0, b100_c};
              opb_q <= {48'd0, t0c_c};
              st_q  <= S_NUM;
            end
          end
        end
        S_NUM: begin
          if (mul_last) begin
            num_q <= accsum[37:0];
            r_q   <= '0;
            q_q   <= '0;
            i_q   <= DIV_TOP;
            st_q  <= S_DIV;
          end
        end
        S_DIV: begin
          r_q <= rr_c;
          q_q <= qc_c;
          i_q <= i_q - 7'd1;
          if (i_q == 7'd0) begin
            if (tmp_c > 44'sd32767) begin
              rt_q <= TEMP_MAX;
              rs_q <= ST_SAT;
            end else if (tmp_c < -44'sd32768) begin
              rt_q <= TEMP_MIN;
              rs_q <= ST_SAT;
            end else begin
              rt_q <= tmp_c[15:0];
              rs_q <= ST_OK;
            end
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_valid_q  <= 1'b1;
            res_temp_q   <= rt_q;
            res_status_q <= rs_q;
            st_q         <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_temp_o   = res_temp_q;
  assign res_status_o = res_status_q;
endmodule
